>>> sv/sdbf_pkg.sv
// sdbf_pkg: shared types, constants and arithmetic helpers for the box filter
// used by the front, queue, back and top level of ssd_detection_box_filter
`default_nettype none

package sdbf_pkg;

  // fixed-point setup
  localparam int MAX_SURFACE    = 8192;
  localparam int EDGE_FRAC_BITS = 14;

  // configuration register indexes
  localparam logic [1:0] REG_CONF_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SURFACE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SURFACE_HEIGHT = 2'd2;

  localparam logic [15:0] CONF_THRESHOLD_RST = 16'd32768;
  localparam logic [13:0] SURFACE_WIDTH_RST  = 14'd640;
  localparam logic [13:0] SURFACE_HEIGHT_RST = 14'd480;

  // proposal queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // datapath widths
  localparam int SCALE_W = 31;              // 16b signed edge times 15b signed surface
  localparam int PIX_W   = 26;              // pixel values with widening and padding
  localparam int PROD_W  = PIX_W + 16;      // pixel times Q0.16 fraction

  // widening fractions in Q0.16, rounded to nearest
  localparam logic signed [15:0] FRAC_X = 16'sd4391;   // 0.067
  localparam logic signed [15:0] FRAC_Y = 16'sd1835;   // 0.028
  localparam logic signed [15:0] FRAC_W = 16'sd9830;   // 0.15
  localparam logic signed [15:0] FRAC_H = 16'sd8520;   // 0.13

  localparam logic signed [SCALE_W:0] SCALE_BIAS =
    (SCALE_W + 1)'((64'sd1 <<< EDGE_FRAC_BITS) - 64'sd1);
  localparam logic signed [PROD_W:0] FRAC_BIAS = (PROD_W + 1)'(65535);

  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [13:0] surface_width;
    logic [13:0] surface_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        confidence;
    logic signed [15:0] edge_left;
    logic signed [15:0] edge_top;
    logic signed [15:0] edge_right;
    logic signed [15:0] edge_bottom;
  } prop_t;

  // surface register clamped to the largest supported surface
  function automatic logic [13:0] eff_surface(input logic [13:0] v);
    logic [13:0] r;
    r = v;
    if ({3'b000, v} > 17'(MAX_SURFACE)) begin
      r = 14'(MAX_SURFACE);
    end
    return r;
  endfunction

  // scaled edge divided by 2^EDGE_FRAC_BITS, truncated toward zero
  function automatic logic signed [PIX_W-1:0] scale_trunc(input logic signed [SCALE_W-1:0] v);
    logic signed [SCALE_W:0] s;
    s = (SCALE_W + 1)'(v) + (v[SCALE_W-1] ? SCALE_BIAS : (SCALE_W + 1)'(0));
    return PIX_W'(s >>> EDGE_FRAC_BITS);
  endfunction

  // pixel times Q0.16 fraction divided by 2^16, truncated toward zero
  function automatic logic signed [PIX_W-1:0] frac_trunc(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] s;
    s = (PROD_W + 1)'(v) + (v[PROD_W-1] ? FRAC_BIAS : (PROD_W + 1)'(0));
    return PIX_W'(s >>> 16);
  endfunction

endpackage

`default_nettype wire

>>> sv/ssd_detection_box_filter_top.sv
// ssd_detection_box_filter_top: front classifier, 4-word proposal queue and box pipeline
// depends on sdbf_pkg, sdbf_front, sdbf_queue, sdbf_back
// path from an accepting edge to a valid box word: the queue write on that edge,
//   then 5 stages and the out reg
// throughput: one word per cycle; the queue fills when the output word is held,
//   and the front stalls when the queue is full
// reset: synchronous; clears stop flag, queue, pipeline valids; registers take reset values
`default_nettype none

module ssd_detection_box_filter_top (
  input  logic               clk,
  input  logic               rst,
  // proposal channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               end_marker,
  input  logic               frame_last,
  input  logic [15:0]        confidence,
  input  logic signed [15:0] edge_left,
  input  logic signed [15:0] edge_top,
  input  logic signed [15:0] edge_right,
  input  logic signed [15:0] edge_bottom,
  // box channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        box_x,
  output logic [12:0]        box_y,
  output logic [13:0]        box_w,
  output logic [13:0]        box_h,
  output logic [15:0]        conf_out,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sdbf_pkg::cfg_t  cfg;
  sdbf_pkg::prop_t push_data;
  sdbf_pkg::prop_t q_data;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;

  // registers are always writable; the user must write them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // register file; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= sdbf_pkg::CONF_THRESHOLD_RST;
      cfg.surface_width  <= sdbf_pkg::SURFACE_WIDTH_RST;
      cfg.surface_height <= sdbf_pkg::SURFACE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdbf_pkg::REG_CONF_THRESHOLD: cfg.conf_threshold <= cfg_data;
        sdbf_pkg::REG_SURFACE_WIDTH:  cfg.surface_width  <= cfg_data[13:0];
        sdbf_pkg::REG_SURFACE_HEIGHT: cfg.surface_height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // front: stop tracking and threshold, pushes survivors into the queue
  sdbf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .end_marker     (end_marker),
    .frame_last     (frame_last),
    .confidence     (confidence),
    .edge_left      (edge_left),
    .edge_top       (edge_top),
    .edge_right     (edge_right),
    .edge_bottom    (edge_bottom),
    .conf_threshold (cfg.conf_threshold),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  // decouples the front from back-pressure on the box channel
  sdbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // back: scale, widen, square, drop off-surface boxes and hold the result word
  sdbf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .pop            (pop),
    .surface_width  (cfg.surface_width),
    .surface_height (cfg.surface_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .box_x          (box_x),
    .box_y          (box_y),
    .box_w          (box_w),
    .box_h          (box_h),
    .conf_out       (conf_out)
  );

endmodule

`default_nettype wire

>>> sv/sdbf_front.sv
// sdbf_front: accepts proposals, tracks the end-of-frame stop and applies the threshold
// depends on sdbf_pkg
`default_nettype none

module sdbf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 end_marker,
  input  logic                 frame_last,
  input  logic [15:0]          confidence,
  input  logic signed [15:0]   edge_left,
  input  logic signed [15:0]   edge_top,
  input  logic signed [15:0]   edge_right,
  input  logic signed [15:0]   edge_bottom,
  input  logic [15:0]          conf_threshold,
  input  logic                 q_full,
  output logic                 push,
  output sdbf_pkg::prop_t      push_data
);

  logic stopped;
  logic take;
  logic consider;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign consider = !stopped && !end_marker && (confidence >= conf_threshold);
  assign push     = take && consider;

  assign push_data.confidence  = confidence;
  assign push_data.edge_left   = edge_left;
  assign push_data.edge_top    = edge_top;
  assign push_data.edge_right  = edge_right;
  assign push_data.edge_bottom = edge_bottom;

  // frame_last wins over an end marker in the same word
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (take) begin
      if (frame_last) begin
        stopped <= 1'b0;
      end else if (end_marker) begin
        stopped <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sdbf_queue.sv
// sdbf_queue: short fifo of kept proposals between front and back
// depends on sdbf_pkg
`default_nettype none

module sdbf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sdbf_pkg::prop_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output sdbf_pkg::prop_t  pop_data
);

  sdbf_pkg::prop_t                mem [sdbf_pkg::QDEPTH];
  logic [sdbf_pkg::QAW-1:0]       wr_ptr;
  logic [sdbf_pkg::QAW-1:0]       rd_ptr;
  logic [sdbf_pkg::QAW:0]         count;
  logic                           do_pop;

  assign full      = (count == (sdbf_pkg::QAW + 1)'(sdbf_pkg::QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sdbf_back.sv
// sdbf_back: five-stage box pipeline (scale, size, widen, widen, square), clipping out reg
// depends on sdbf_pkg
`default_nettype none

module sdbf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sdbf_pkg::prop_t  q_data,
  output logic             pop,
  input  logic [13:0]      surface_width,
  input  logic [13:0]      surface_height,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [12:0]      box_x,
  output logic [12:0]      box_y,
  output logic [13:0]      box_w,
  output logic [13:0]      box_h,
  output logic [15:0]      conf_out
);

  localparam int PW = sdbf_pkg::PIX_W;

  logic [13:0] sw_eff;
  logic [13:0] sh_eff;
  logic signed [PW-1:0] sw_s;
  logic signed [PW-1:0] sh_s;
  logic adv;

  // stage 1: edge times surface
  logic v1;
  logic [15:0] s1_conf;
  logic signed [sdbf_pkg::SCALE_W-1:0] s1_pl, s1_pt, s1_pr, s1_pb;
  // stage 2: pixel box
  logic v2;
  logic [15:0] s2_conf;
  logic signed [PW-1:0] s2_x, s2_y, s2_w, s2_h;
  // stage 3: widening products
  logic v3;
  logic [15:0] s3_conf;
  logic signed [PW-1:0] s3_x, s3_y, s3_w, s3_h;
  logic signed [sdbf_pkg::PROD_W-1:0] s3_px, s3_py, s3_pw, s3_ph;
  // stage 4: widened box
  logic v4;
  logic [15:0] s4_conf;
  logic signed [PW-1:0] s4_x, s4_y, s4_w, s4_h;
  // stage 5: square box
  logic v5;
  logic [15:0] s5_conf;
  logic signed [PW-1:0] s5_x, s5_y, s5_w, s5_h;

  logic signed [PW-1:0] pad_x, pad_y, pad_w, pad_h, pad_d;
  logic signed [PW-1:0] x_end, y_end;
  logic keep;

  assign sw_eff = sdbf_pkg::eff_surface(surface_width);
  assign sh_eff = sdbf_pkg::eff_surface(surface_height);
  assign sw_s   = signed'(PW'(sw_eff));
  assign sh_s   = signed'(PW'(sh_eff));

  // the whole pipeline moves together unless the output word is held
  assign adv = !out_valid || !out_stall;
  assign pop = q_valid && adv;

  always_comb begin
    pad_x = s4_x;
    pad_y = s4_y;
    pad_w = s4_w;
    pad_h = s4_h;
    if (s4_w < s4_h) begin
      pad_d = s4_h - s4_w;
      pad_x = s4_x - (pad_d >>> 1);
      pad_w = s4_h;
    end else begin
      pad_d = s4_w - s4_h;
      pad_y = s4_y - (pad_d >>> 1);
      pad_h = s4_w;
    end
  end

  assign x_end = s5_x + s5_w;
  assign y_end = s5_y + s5_h;
  assign keep  = (s5_w > 0) && (s5_h > 0) && (s5_x >= 0) && (s5_y >= 0) &&
                 (x_end <= sw_s) && (y_end <= sh_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5 && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_conf <= q_data.confidence;
      s1_pl   <= q_data.edge_left   * $signed({1'b0, sw_eff});
      s1_pt   <= q_data.edge_top    * $signed({1'b0, sh_eff});
      s1_pr   <= q_data.edge_right  * $signed({1'b0, sw_eff});
      s1_pb   <= q_data.edge_bottom * $signed({1'b0, sh_eff});

      s2_conf <= s1_conf;
      s2_x    <= sdbf_pkg::scale_trunc(s1_pl);
      s2_y    <= sdbf_pkg::scale_trunc(s1_pt);
      s2_w    <= sdbf_pkg::scale_trunc(s1_pr) - sdbf_pkg::scale_trunc(s1_pl);
      s2_h    <= sdbf_pkg::scale_trunc(s1_pb) - sdbf_pkg::scale_trunc(s1_pt);

      s3_conf <= s2_conf;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_w    <= s2_w;
      s3_h    <= s2_h;
      s3_px   <= s2_w * sdbf_pkg::FRAC_X;
      s3_py   <= s2_h * sdbf_pkg::FRAC_Y;
      s3_pw   <= s2_w * sdbf_pkg::FRAC_W;
      s3_ph   <= s2_h * sdbf_pkg::FRAC_H;

      s4_conf <= s3_conf;
      s4_x    <= s3_x - sdbf_pkg::frac_trunc(s3_px);
      s4_y    <= s3_y - sdbf_pkg::frac_trunc(s3_py);
      s4_w    <= s3_w + sdbf_pkg::frac_trunc(s3_pw);
      s4_h    <= s3_h + sdbf_pkg::frac_trunc(s3_ph);

      s5_conf <= s4_conf;
      s5_x    <= pad_x;
      s5_y    <= pad_y;
      s5_w    <= pad_w;
      s5_h    <= pad_h;

      box_x    <= s5_x[12:0];
      box_y    <= s5_y[12:0];
      box_w    <= s5_w[13:0];
      box_h    <= s5_h[13:0];
      conf_out <= s5_conf;
    end
  end

endmodule

`default_nettype wire

>>> sv/sdbf_checker.sv
// sdbf_checker: port-level assertions for the box filter, bound to the top level
// depends on ssd_detection_box_filter_top ports only
`default_nettype none

module sdbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] box_x,
  input logic [12:0] box_y,
  input logic [13:0] box_w,
  input logic [13:0] box_h,
  input logic [15:0] conf_out
);

  // a held box word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("box word dropped while stalled");

  // a held box word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(box_x) && $stable(box_y) && $stable(box_w) &&
                               $stable(box_h) && $stable(conf_out))
    else $error("box payload changed while stalled");

  // every emitted box is padded to a non-empty square
  a_square: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_w == box_h) && (box_w != 14'd0))
    else $error("emitted box is not a non-empty square");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("box word valid after reset");

endmodule

bind ssd_detection_box_filter_top sdbf_checker u_sdbf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .box_x     (box_x),
  .box_y     (box_y),
  .box_w     (box_w),
  .box_h     (box_h),
  .conf_out  (conf_out)
);

`default_nettype wire

>>> verif/tb.sv
// tb: self-checking bench for ssd_detection_box_filter_top, proposals in and kept boxes out
// depends on sdbf_pkg for register indexes, reset values and the surface limit, and on the block's rtl
// a box scoreboard predicts every kept box in order and checks each accepted box word

typedef struct packed {
  logic               end_marker;
  logic               frame_last;
  logic [15:0]        confidence;
  logic signed [15:0] edge_left;
  logic signed [15:0] edge_top;
  logic signed [15:0] edge_right;
  logic signed [15:0] edge_bottom;
} proposal_t;

typedef struct packed {
  logic [12:0] x;
  logic [12:0] y;
  logic [13:0] w;
  logic [13:0] h;
  logic [15:0] conf;
} box_t;

class box_scoreboard;
  // widening fractions, q0.16
  localparam longint WIDEN_X = 4391;
  localparam longint WIDEN_Y = 1835;
  localparam longint WIDEN_W = 9830;
  localparam longint WIDEN_H = 8520;
  localparam longint EDGE_ONE = 16384;
  localparam longint FRAC_ONE = 65536;

  logic [15:0] thr;
  logic [13:0] width_reg;
  logic [13:0] height_reg;
  bit          stopped;
  box_t        boxes_due[$];
  int          errors;

  function new();
    thr        = sdbf_pkg::CONF_THRESHOLD_RST;
    width_reg  = sdbf_pkg::SURFACE_WIDTH_RST;
    height_reg = sdbf_pkg::SURFACE_HEIGHT_RST;
    stopped    = 1'b0;
    errors     = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      sdbf_pkg::REG_CONF_THRESHOLD: thr = data;
      sdbf_pkg::REG_SURFACE_WIDTH:  width_reg = data[13:0];
      sdbf_pkg::REG_SURFACE_HEIGHT: height_reg = data[13:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return boxes_due.size();
  endfunction

  // filter one accepted proposal, queue its box if one is kept
  function void note_word(proposal_t p);
    longint sw, sh, x, y, w, h, wd, hd, d;
    bit     keep;
    box_t   b;
    keep = !stopped && !p.end_marker && (p.confidence >= thr);
    if (p.end_marker) stopped = 1'b1;
    if (p.frame_last) stopped = 1'b0;
    if (!keep) return;
    sw = width_reg;
    if (sw > sdbf_pkg::MAX_SURFACE) sw = sdbf_pkg::MAX_SURFACE;
    sh = height_reg;
    if (sh > sdbf_pkg::MAX_SURFACE) sh = sdbf_pkg::MAX_SURFACE;
    x = longint'($signed(p.edge_left)) * sw / EDGE_ONE;
    y = longint'($signed(p.edge_top)) * sh / EDGE_ONE;
    w = longint'($signed(p.edge_right)) * sw / EDGE_ONE - x;
    h = longint'($signed(p.edge_bottom)) * sh / EDGE_ONE - y;
    wd = w;
    hd = h;
    x = x - wd * WIDEN_X / FRAC_ONE;
    y = y - hd * WIDEN_Y / FRAC_ONE;
    w = w + wd * WIDEN_W / FRAC_ONE;
    h = h + hd * WIDEN_H / FRAC_ONE;
    // pad the short side to a square, centered
    if (w < h) begin
      d = h - w;
      x = x - d / 2;
      w = w + d;
    end else begin
      d = w - h;
      y = y - d / 2;
      h = h + d;
    end
    if (w > 0 && h > 0 && x >= 0 && y >= 0 && x + w <= sw && y + h <= sh) begin
      b.x    = 13'(x);
      b.y    = 13'(y);
      b.w    = 14'(w);
      b.h    = 14'(h);
      b.conf = p.confidence;
      boxes_due = {boxes_due, b};
    end
  endfunction

  function void mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  function void check_word(box_t got);
    box_t want;
    if (boxes_due.size() == 0) begin
      $display("%0t: unexpected box, expected none, actual x=%0d y=%0d w=%0d h=%0d conf=%0d",
               $time, got.x, got.y, got.w, got.h, got.conf);
      errors++;
      return;
    end
    want = boxes_due.pop_front();
    if (got.x !== want.x) mismatch("box_x", want.x, got.x);
    if (got.y !== want.y) mismatch("box_y", want.y, got.y);
    if (got.w !== want.w) mismatch("box_w", want.w, got.w);
    if (got.h !== want.h) mismatch("box_h", want.h, got.h);
    if (got.conf !== want.conf) mismatch("conf_out", want.conf, got.conf);
  endfunction
endclass

module tb;

  localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
  localparam int         SETTLE_CYCLES  = 12;    // lets dropped words clear the pipeline after the last due box
  localparam logic [1:0] REG_SPARE      = 2'd3;  // unmapped index, must be ignored

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_HELD} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  // proposal channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  proposal_t   word_in = '0;

  // box channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] box_x;
  logic [12:0] box_y;
  logic [13:0] box_w;
  logic [13:0] box_h;
  logic [15:0] conf_out;

  // register write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  box_scoreboard sb = new();

  int       frame_slots_left = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;

  ssd_detection_box_filter_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .end_marker (word_in.end_marker),
    .frame_last (word_in.frame_last),
    .confidence (word_in.confidence),
    .edge_left  (word_in.edge_left),
    .edge_top   (word_in.edge_top),
    .edge_right (word_in.edge_right),
    .edge_bottom(word_in.edge_bottom),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_w      (box_w),
    .box_h      (box_h),
    .conf_out   (conf_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: stretches of free flow, choppy stalls and held stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HELD) ? $urandom_range(1, 30) : $urandom_range(10, 120);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_CHOPPY: out_stall <= ($urandom_range(0, 99) < 40);
      default:   out_stall <= 1'b1;
    endcase
  end

  // box monitor and watchdog; values read here are the ones from before the edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_word(box_t'({box_x, box_y, box_w, box_h, conf_out}));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles, %0d boxes still due",
                 $time, quiet_cycles, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic proposal_t make_prop(logic endm, logic last, logic [15:0] conf,
                                          logic [15:0] l, logic [15:0] t,
                                          logic [15:0] r, logic [15:0] b);
    proposal_t p;
    p.end_marker  = endm;
    p.frame_last  = last;
    p.confidence  = conf;
    p.edge_left   = l;
    p.edge_top    = t;
    p.edge_right  = r;
    p.edge_bottom = b;
    return p;
  endfunction

  // mostly well-formed boxes around the threshold, some noise and end markers;
  // frame_last closes frames of random length so the stop flag gets cleared
  function automatic proposal_t random_proposal(logic [15:0] thr);
    proposal_t p;
    int        pick;
    int        lft;
    int        tp;
    p    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      p.confidence  = 16'($urandom);
      p.edge_left   = 16'($urandom);
      p.edge_top    = 16'($urandom);
      p.edge_right  = 16'($urandom);
      p.edge_bottom = 16'($urandom);
      p.end_marker  = ($urandom_range(0, 15) == 0);
      p.frame_last  = ($urandom_range(0, 15) == 0);
    end else begin
      case ($urandom_range(0, 9))
        0:       p.confidence = thr;
        1:       p.confidence = thr - 16'd1;
        2, 3:    p.confidence = 16'($urandom);
        default: p.confidence = 16'($urandom_range(int'(thr), 65535));
      endcase
      if (pick < 25) begin
        // wide boxes, some reach over the whole surface
        p.edge_left   = 16'($urandom_range(0, 3000));
        p.edge_top    = 16'($urandom_range(0, 3000));
        p.edge_right  = 16'($urandom_range(13000, 20000));
        p.edge_bottom = 16'($urandom_range(13000, 20000));
      end else begin
        lft = $urandom_range(600, 11000);
        tp  = $urandom_range(600, 11000);
        p.edge_left   = 16'(lft);
        p.edge_top    = 16'(tp);
        p.edge_right  = 16'(lft + $urandom_range(50, 3500));
        p.edge_bottom = 16'(tp + $urandom_range(50, 3500));
      end
      p.end_marker = (pick >= 97);
    end
    if (frame_slots_left == 0) begin
      p.frame_last     = 1'b1;
      frame_slots_left = $urandom_range(4, 40);
    end else begin
      frame_slots_left = frame_slots_left - 1;
    end
    return p;
  endfunction

  // present one proposal word and hold it until taken
  task automatic send(proposal_t p);
    word_in  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(p);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] thr, logic [15:0] sw, logic [15:0] sh);
    write_reg(sdbf_pkg::REG_CONF_THRESHOLD, thr);
    write_reg(sdbf_pkg::REG_SURFACE_WIDTH, sw);
    write_reg(sdbf_pkg::REG_SURFACE_HEIGHT, sh);
  endtask

  // wait for every due box, then let dropped words clear the pipeline
  task automatic settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random proposals in bursts with random gaps, some gaps of zero
  task automatic run_phase(int n_items);
    int gap;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 19) == 0) gap = 25;
        if (gap > 0) pause(gap);
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
      end
      send(random_proposal(sb.thr));
      burst_left = burst_left - 1;
    end
    pause(1);
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings: 640x480, threshold one half
    send(make_prop(1'b0, 1'b0, 16'd32768, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b0, 16'd32767, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'd6000, 16'd5000, 16'd9000, 16'd9000));
    send(make_prop(1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    // most negative and most positive edges
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    pause(2);
    send(make_prop(1'b0, 1'b0, 16'd50000, 16'd0, 16'd0, 16'h7fff, 16'h7fff));
    // small negative edges truncate toward zero
    send(make_prop(1'b0, 1'b0, 16'd50000, 16'hfff6, 16'hfff6, 16'd3000, 16'd3000));
    // inverted and zero-size boxes are dropped, never flipped
    send(make_prop(1'b0, 1'b0, 16'd50000, 16'd9000, 16'd9000, 16'd5000, 16'd5000));
    send(make_prop(1'b0, 1'b0, 16'd50000, 16'd5000, 16'd5000, 16'd5000, 16'd5000));
    // tall box, padded sideways
    send(make_prop(1'b0, 1'b0, 16'd40000, 16'd7000, 16'd2000, 16'd8000, 16'd12000));
    send(make_prop(1'b0, 1'b1, 16'd50000, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    pause(2);
    // end marker stops the frame; the last slot is still dropped, then clears
    send(make_prop(1'b1, 1'b0, 16'hffff, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b1, 16'hffff, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    // end marker on the last slot itself
    send(make_prop(1'b1, 1'b1, 16'hffff, 16'd4096, 16'd4096, 16'd8192, 16'd8192));
    send(make_prop(1'b0, 1'b0, 16'd60000, 16'd5000, 16'd6000, 16'd9000, 16'd8000));
    send(make_prop(1'b1, 1'b0, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send(make_prop(1'b0, 1'b0, 16'hffff, 16'd5000, 16'd6000, 16'd9000, 16'd8000));
    send(make_prop(1'b0, 1'b1, 16'd40000, 16'd5000, 16'd6000, 16'd9000, 16'd8000));
    send(make_prop(1'b0, 1'b0, 16'd40000, 16'd2000, 16'd3000, 16'd12000, 16'd14000));

    run_phase(250);

    // every proposal passes the threshold, largest surface
    configure(16'd0, 16'd8192, 16'd8192);
    run_phase(300);

    // top threshold on a one pixel surface
    configure(16'hffff, 16'd1, 16'd1);
    run_phase(100);

    // zero width keeps nothing; the unmapped index must change nothing
    configure(16'd16384, 16'd0, 16'd480);
    write_reg(REG_SPARE, 16'hffff);
    run_phase(60);

    // surface registers above the limit act as the limit
    configure(16'd40000, 16'h3fff, 16'd8193);
    run_phase(200);

    configure(16'($urandom), 16'($urandom_range(1, 8192)), 16'($urandom_range(1, 8192)));
    run_phase(300);

    configure(16'd20000, 16'd1920, 16'd1080);
    run_phase(400);

    // high data bits beyond the register width are dropped
    configure(16'd32768, 16'hc280, 16'hc1e0);
    run_phase(300);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
